// ===== hw/rtl/cfnp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfnp_pkg: shared types and constants of the cascaded FIR pair
// Payload structs, cell control and data structs, and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package cfnp_pkg;

  // Fixed arithmetic widths
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned ACC_W      = 40;
  localparam int unsigned Q_SHIFT    = 15;
  localparam int unsigned COEF_IDX_W = 6;

  // Command codes of an input transaction
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // Filter stage codes
  localparam logic STAGE_FIRST  = 1'b0;
  localparam logic STAGE_SECOND = 1'b1;

  typedef struct packed {
    logic                          cmd;
    logic signed [DATA_W-1:0]      sample_in;
    logic                          coef_stage;
    logic        [COEF_IDX_W-1:0]  coef_index;
    logic signed [DATA_W-1:0]      coef_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_out;
    logic                     clipped;
  } out_t;

  // Control broadcast to every cell of the ring
  typedef struct packed {
    logic                     adv1;        // move line-one samples one cell on
    logic                     rot1;        // move stage-one coefficients one cell on
    logic                     adv2;        // move line-two samples one cell on
    logic                     rot2;        // move stage-two coefficients one cell on
    logic                     load;        // coefficient write to the selected cell
    logic                     load_stage;
    logic signed [DATA_W-1:0] coef_value;
  } cell_ctrl_t;

  // Contents handed from one cell to the next
  typedef struct packed {
    logic signed [DATA_W-1:0] sample1;
    logic signed [DATA_W-1:0] coef1;
    logic signed [DATA_W-1:0] sample2;
    logic signed [DATA_W-1:0] coef2;
  } cell_data_t;

endpackage

// ===== hw/rtl/cascaded_fir_notch_pair.sv =====
// ----------------------------------------------------------------------------
// cascaded_fir_notch_pair: two FIR filters in series on one audio channel
// Ring of tap cells with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// An audio sample (cmd 0) passes from acceptance through RUN1, DRAIN1,
// FIN1, RUN2, DRAIN2 and FIN2 before its result is offered, plus any wait
// for the output register to drain. The sequence is set by the single
// multiply-accumulate unit, which reads one tap per cycle from the head of a
// ring of TAPS cells: stage one rotates line one and its coefficients a full
// turn, the scaled and saturated stage-one result is pushed into line two,
// then stage two makes its own full turn. A coefficient load (cmd 1)
// makes no output transaction and is ignored when coef_index is TAPS or more.
// Input is taken only while no sample is in flight; a finished result waits
// in the output register so the next transaction can already be accepted.
// Coefficients are not reset and must be loaded before samples are sent.
// output_stage selects the stage-one (0) or cascaded stage-two (1) result;
// clipped reports saturation in either stage for that sample.
// ----------------------------------------------------------------------------
module cascaded_fir_notch_pair
  import cfnp_pkg::*;
#(
  parameter int unsigned TAPS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o,
  input  logic cfg_we_i,
  input  logic cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(TAPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN1,
    ST_DRAIN1,
    ST_FIN1,
    ST_RUN2,
    ST_DRAIN2,
    ST_FIN2
  } state_e;

  state_e                   state_q;
  logic     [CNT_W-1:0]     cnt_q;
  logic                     sat1_q;
  logic signed [DATA_W-1:0] y1_q;
  logic                     out_valid_q;
  out_t                     out_data_q;
  logic                     output_stage_q;

  cell_ctrl_t               ctrl;
  cell_data_t               cell_out [TAPS];
  cell_data_t               ring_in;
  cell_data_t               head;
  logic       [TAPS-1:0]    cell_sel;

  logic                     in_acc;
  logic                     take_sample;
  logic                     take_coef;
  logic                     cnt_last;
  logic                     out_free;

  logic                     mac_clr;
  logic                     mac_en;
  logic signed [DATA_W-1:0] mac_coef;
  logic signed [DATA_W-1:0] mac_sample;
  logic signed [DATA_W-1:0] mac_y;
  logic                     mac_sat;

  // Handshake: accept only with no sample in flight
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign take_sample = in_acc && (in_data_i.cmd == CMD_SAMPLE);
  assign take_coef   = in_acc && (in_data_i.cmd == CMD_COEF);
  assign cnt_last    = (cnt_q == CNT_W'(TAPS - 1));
  assign out_free    = !out_valid_q || out_ready_i;

  // Ring control: push advances samples only; a turn moves samples and coefficients
  always_comb begin
    ctrl.adv1       = take_sample || (state_q == ST_RUN1);
    ctrl.rot1       = (state_q == ST_RUN1);
    ctrl.adv2       = (state_q == ST_FIN1) || (state_q == ST_RUN2);
    ctrl.rot2       = (state_q == ST_RUN2);
    ctrl.load       = take_coef;
    ctrl.load_stage = in_data_i.coef_stage;
    ctrl.coef_value = in_data_i.coef_value;
  end

  // Head of the ring feeds the MAC and wraps round to the first cell
  assign head = cell_out[TAPS-1];

  always_comb begin
    ring_in         = head;
    if (state_q == ST_IDLE) begin
      ring_in.sample1 = in_data_i.sample_in;
    end
    if (state_q == ST_FIN1) begin
      ring_in.sample2 = mac_y;
    end
  end

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    // Out-of-range tap indices match no cell, so such a load is dropped
    assign cell_sel[i] = (32'(in_data_i.coef_index) == i);

    if (i == 0) begin : g_first
      cfnp_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .sel_i  (cell_sel[i]),
        .data_i (ring_in),
        .data_o (cell_out[i])
      );
    end else begin : g_next
      cfnp_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .sel_i  (cell_sel[i]),
        .data_i (cell_out[i-1]),
        .data_o (cell_out[i])
      );
    end
  end

  // Shared MAC: clear at the start of each stage, enable for one full turn
  assign mac_clr    = take_sample || (state_q == ST_FIN1);
  assign mac_en     = (state_q == ST_RUN1) || (state_q == ST_RUN2);
  assign mac_coef   = (state_q == ST_RUN2) ? head.coef2   : head.coef1;
  assign mac_sample = (state_q == ST_RUN2) ? head.sample2 : head.sample1;

  cfnp_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (mac_clr),
    .en_i     (mac_en),
    .coef_i   (mac_coef),
    .sample_i (mac_sample),
    .y_o      (mac_y),
    .sat_o    (mac_sat)
  );

  // Sequencer, output register and configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      sat1_q         <= 1'b0;
      y1_q           <= '0;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
      output_stage_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        output_stage_q <= cfg_data_i;
      end
      // Drop the result once the consumer takes it
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (take_sample) begin
            state_q <= ST_RUN1;
          end
        end
        ST_RUN1: begin
          cnt_q <= cnt_last ? '0 : cnt_q + CNT_W'(1);
          if (cnt_last) begin
            state_q <= ST_DRAIN1;
          end
        end
        ST_DRAIN1: begin
          state_q <= ST_FIN1;
        end
        ST_FIN1: begin
          // Hold the stage-one result for selection at the end
          sat1_q  <= mac_sat;
          y1_q    <= mac_y;
          state_q <= ST_RUN2;
        end
        ST_RUN2: begin
          cnt_q <= cnt_last ? '0 : cnt_q + CNT_W'(1);
          if (cnt_last) begin
            state_q <= ST_DRAIN2;
          end
        end
        ST_DRAIN2: begin
          state_q <= ST_FIN2;
        end
        ST_FIN2: begin
          // Hold here until the output register is free
          if (out_free) begin
            out_valid_q        <= 1'b1;
            out_data_q.clipped <= sat1_q || mac_sat;
            out_data_q.sample_out <= (output_stage_q == STAGE_SECOND) ? mac_y : y1_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The ring is back at its home position whenever a new transaction may enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q == '0))
    else $error("ring not at home position when idle");

  // An accepted sample starts a stage-one turn from the first tap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_sample |=> (state_q == ST_RUN1) && (cnt_q == '0))
    else $error("sample accepted without starting stage one");

  // Coefficients never rotate without their samples, and the lines never move together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctrl.rot1 || ctrl.adv1) && (!ctrl.rot2 || ctrl.adv2) && !(ctrl.adv1 && ctrl.adv2))
    else $error("inconsistent ring control");

  // A new result is only written when the previous one has gone or is leaving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN2) && out_valid_q && !out_ready_i |=> (state_q == ST_FIN2))
    else $error("result overwritten before it was taken");

  // A waiting result keeps its payload until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_data_q))
    else $error("output payload changed while waiting");

endmodule

// ===== hw/rtl/cfnp_cell.sv =====
// ----------------------------------------------------------------------------
// cfnp_cell: one tap cell of the cascaded FIR ring
// Holds one sample and one coefficient of each stage; hands them on when told.
// ----------------------------------------------------------------------------
module cfnp_cell
  import cfnp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       sel_i,
  input  cell_data_t data_i,
  output cell_data_t data_o
);

  logic signed [DATA_W-1:0] sample1_q, sample2_q;
  logic signed [DATA_W-1:0] coef1_q, coef2_q;

  // Delay-line samples clear at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample1_q <= '0;
      sample2_q <= '0;
    end else begin
      if (ctrl_i.adv1) begin
        sample1_q <= data_i.sample1;
      end
      if (ctrl_i.adv2) begin
        sample2_q <= data_i.sample2;
      end
    end
  end

  // Coefficients are undefined until loaded
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && sel_i && ctrl_i.load_stage == STAGE_FIRST) begin
      coef1_q <= ctrl_i.coef_value;
    end else if (ctrl_i.rot1) begin
      coef1_q <= data_i.coef1;
    end
    if (ctrl_i.load && sel_i && ctrl_i.load_stage == STAGE_SECOND) begin
      coef2_q <= ctrl_i.coef_value;
    end else if (ctrl_i.rot2) begin
      coef2_q <= data_i.coef2;
    end
  end

  assign data_o.sample1 = sample1_q;
  assign data_o.coef1   = coef1_q;
  assign data_o.sample2 = sample2_q;
  assign data_o.coef2   = coef2_q;

endmodule

// ===== hw/rtl/cfnp_mac.sv =====
// ----------------------------------------------------------------------------
// cfnp_mac: shared multiply-accumulate unit
// Registered 16x16 product, 40-bit accumulator, Q1.15 scaling and saturation.
// ----------------------------------------------------------------------------
module cfnp_mac
  import cfnp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  logic                     en_i,
  input  logic signed [DATA_W-1:0] coef_i,
  input  logic signed [DATA_W-1:0] sample_i,
  output logic signed [DATA_W-1:0] y_o,
  output logic                     sat_o
);

  localparam int unsigned TOP_LSB = Q_SHIFT + DATA_W - 1;

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic        [ACC_W-1:0]  acc_q;
  logic        [ACC_W-1:TOP_LSB] top_bits;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= coef_i * sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= en_i;
      if (clr_i) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
      end
    end
  end

  // Floor shift by Q_SHIFT; saturate when the result's sign bit and the bits above it disagree
  assign top_bits = acc_q[ACC_W-1:TOP_LSB];
  assign sat_o    = !((&top_bits) || !(|top_bits));

  always_comb begin
    if (!sat_o) begin
      y_o = acc_q[TOP_LSB:Q_SHIFT];
    end else if (acc_q[ACC_W-1]) begin
      y_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      y_o = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule
